// ===== design/mfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfpe_pkg - shared types for the one-bit framebuffer pixel engine
// Holds the command and result formats, operation codes, register indexes.
// ----------------------------------------------------------------------------
package mfpe_pkg;

    // operation codes
    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_SET        = 3'd1;
    localparam logic [2:0] OP_INVERT     = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;
    localparam logic [2:0] OP_FILL_ALL   = 3'd5;
    localparam logic [2:0] OP_INVERT_ALL = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_CANVAS_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_CANVAS_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CLIP_LEFT     = 3'd2;
    localparam logic [2:0] CFG_CLIP_TOP      = 3'd3;
    localparam logic [2:0] CFG_CLIP_SPAN_X   = 3'd4;
    localparam logic [2:0] CFG_CLIP_SPAN_Y   = 3'd5;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } mfpe_cmd_t;

    typedef struct packed {
        logic accepted;
        logic pixel_value;
    } mfpe_res_t;

endpackage

// ===== design/mfpe_store.sv =====
// ----------------------------------------------------------------------------
// mfpe_store - frame byte store
// Single-port byte memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mfpe_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mono_framebuffer_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_engine - one-bit packed framebuffer engine
// Pixel set/clear/invert inside a clip window, pixel read, whole-canvas
// clear/fill/invert over an MSB-first packed byte store.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload   | direction
//  --------+-----------+-----------+-----------+----------
//  command | cmd_valid | cmd_stall | cmd       | into block
//  result  | res_valid | res_stall | res       | out of block
//  config  | cfg_we    | (none)    | cfg_index, cfg_data | into block
//
//  Sequence: a pixel operation passes check, read, modify and hand-off
//  before its result is raised, or check and hand-off alone when it misses
//  the bounds or clip or the canvas is invalid; clear/fill-all write one
//  canvas byte per cycle, invert-all reads then writes each byte via the
//  single store port. A new command can transfer once the result is raised.
//  Reset: after rst_n releases, a clearing pass writes zero to all
//  ceil(MAX_WIDTH/8)*MAX_HEIGHT bytes, one per cycle, with cmd_stall high.
//  Stalls: one command is in work at a time; a finished result waits in the
//  output register while res_stall is high, and the next result holds until
//  that register is free.
// ----------------------------------------------------------------------------
module mono_framebuffer_pixel_engine
    import mfpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  mfpe_cmd_t             cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output mfpe_res_t             res,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_BYTES = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    // wide enough for the store size itself and for a 13-bit row offset
    localparam int SUM_W       = (ADDR_W + 1 > 14) ? (ADDR_W + 1) : 14;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_INV_RD,
        ST_INV_WR,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]         width_reg;
    logic [6:0]         height_reg;
    logic signed [15:0] clip_left_reg;
    logic signed [15:0] clip_top_reg;
    logic [14:0]        span_x_reg;
    logic [14:0]        span_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 8'd128;
            height_reg    <= 7'd64;
            clip_left_reg <= '0;
            clip_top_reg  <= '0;
            span_x_reg    <= 15'd128;
            span_y_reg    <= 15'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  width_reg     <= cfg_data[7:0];
                CFG_CANVAS_HEIGHT: height_reg    <= cfg_data[6:0];
                CFG_CLIP_LEFT:     clip_left_reg <= cfg_data;
                CFG_CLIP_TOP:      clip_top_reg  <= cfg_data;
                CFG_CLIP_SPAN_X:   span_x_reg    <= cfg_data[14:0];
                CFG_CLIP_SPAN_Y:   span_y_reg    <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Canvas geometry derived from configuration
    // ------------------------------------------------------------------
    logic [8:0]       width_round;
    logic [5:0]       stride;
    logic [12:0]      canvas_size;
    logic [SUM_W-1:0] size_wide;
    logic             canvas_ok;
    logic [2:0]       used_bits;
    logic [7:0]       keep_mask;

    assign width_round = {1'b0, width_reg} + 9'd7;
    assign stride      = width_round[8:3];
    assign canvas_size = 13'(stride) * 13'(height_reg);
    assign size_wide   = SUM_W'(canvas_size);
    assign canvas_ok   = (width_reg != 8'd0) && (height_reg != 7'd0)
                         && (size_wide <= SUM_W'(STORE_BYTES));
    assign used_bits   = width_reg[2:0];
    // padding bits at the end of a row are kept at zero
    assign keep_mask   = (used_bits == 3'd0) ? 8'hFF : ~(8'hFF >> used_bits);

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t            state_reg;
    mfpe_cmd_t         cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [4:0]        col_reg;
    logic [7:0]        mask_reg;
    logic              acc_reg;
    logic              pix_reg;
    logic              res_valid_reg;
    mfpe_res_t         res_reg;

    // ------------------------------------------------------------------
    // Bounds and clip check of the held command (ST_CHECK)
    // ------------------------------------------------------------------
    logic signed [17:0] pos_x_ext;
    logic signed [17:0] pos_y_ext;
    logic signed [17:0] clip_l;
    logic signed [17:0] clip_t;
    logic signed [17:0] clip_r;
    logic signed [17:0] clip_b;
    logic signed [17:0] canvas_w;
    logic signed [17:0] canvas_h;
    logic               in_bounds;
    logic               in_clip;
    logic               pixel_ok;
    logic [12:0]        row_base;
    logic [SUM_W-1:0]   idx_wide;

    assign pos_x_ext = 18'(cmd_reg.pos_x);
    assign pos_y_ext = 18'(cmd_reg.pos_y);
    assign clip_l    = 18'(clip_left_reg);
    assign clip_t    = 18'(clip_top_reg);
    assign clip_r    = clip_l + $signed({3'b000, span_x_reg});
    assign clip_b    = clip_t + $signed({3'b000, span_y_reg});
    assign canvas_w  = $signed({10'd0, width_reg});
    assign canvas_h  = $signed({11'd0, height_reg});

    assign in_bounds = !cmd_reg.pos_x[15] && !cmd_reg.pos_y[15]
                       && (pos_x_ext < canvas_w) && (pos_y_ext < canvas_h);
    // the clip window clamped to the canvas is the raw window AND the bounds
    assign in_clip   = in_bounds
                       && (pos_x_ext >= clip_l) && (pos_x_ext < clip_r)
                       && (pos_y_ext >= clip_t) && (pos_y_ext < clip_b);
    assign pixel_ok  = (cmd_reg.op == OP_READ) ? in_bounds : in_clip;

    assign row_base  = 13'(cmd_reg.pos_y[6:0]) * 13'(stride);
    assign idx_wide  = SUM_W'(row_base) + SUM_W'(cmd_reg.pos_x[7:3]);

    // ------------------------------------------------------------------
    // Sweep bookkeeping
    // ------------------------------------------------------------------
    logic sweep_last;
    logic col_last;
    logic init_last;

    assign sweep_last = (SUM_W'(addr_reg) == (size_wide - SUM_W'(1)));
    assign col_last   = ({1'b0, col_reg} == (stride - 6'd1));
    assign init_last  = (addr_reg == ADDR_W'(STORE_BYTES - 1));

    // ------------------------------------------------------------------
    // Store port
    // ------------------------------------------------------------------
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic [7:0] mem_rdata;
    logic [7:0] sweep_keep;

    assign sweep_keep = col_last ? keep_mask : 8'hFF;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 8'h00;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
            end
            ST_MODIFY:
            begin
                mem_we = (cmd_reg.op != OP_READ);
                case (cmd_reg.op)
                    OP_CLEAR: mem_wdata = mem_rdata & ~mask_reg;
                    OP_SET:   mem_wdata = mem_rdata | mask_reg;
                    default:  mem_wdata = mem_rdata ^ mask_reg;
                endcase
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cmd_reg.op == OP_FILL_ALL) ? sweep_keep : 8'h00;
            end
            ST_INV_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = ~mem_rdata & sweep_keep;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    mfpe_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            addr_reg      <= '0;
            col_reg       <= '0;
            acc_reg       <= 1'b0;
            pix_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once it has transferred; the hand-off state
            // reloads the register itself
            if (res_valid_reg && !res_stall && (state_reg != ST_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    // clearing pass over the whole store
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (init_last)
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    acc_reg  <= 1'b0;
                    pix_reg  <= 1'b0;
                    addr_reg <= '0;
                    col_reg  <= '0;
                    if (!canvas_ok)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        case (cmd_reg.op)
                            OP_CLEAR, OP_SET, OP_INVERT, OP_READ:
                            begin
                                addr_reg  <= idx_wide[ADDR_W-1:0];
                                mask_reg  <= 8'h80 >> cmd_reg.pos_x[2:0];
                                state_reg <= pixel_ok ? ST_READ : ST_DONE;
                            end
                            OP_CLEAR_ALL, OP_FILL_ALL:
                            begin
                                state_reg <= ST_FILL;
                            end
                            OP_INVERT_ALL:
                            begin
                                state_reg <= ST_INV_RD;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_MODIFY;
                end

                ST_MODIFY:
                begin
                    if (cmd_reg.op == OP_READ)
                    begin
                        pix_reg <= |(mem_rdata & mask_reg);
                    end
                    else
                    begin
                        acc_reg <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end

                ST_FILL:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    col_reg  <= col_last ? 5'd0 : col_reg + 5'd1;
                    if (sweep_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_INV_RD:
                begin
                    state_reg <= ST_INV_WR;
                end

                ST_INV_WR:
                begin
                    addr_reg  <= addr_reg + ADDR_W'(1);
                    col_reg   <= col_last ? 5'd0 : col_reg + 5'd1;
                    state_reg <= sweep_last ? ST_DONE : ST_INV_RD;
                end

                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg       <= 1'b1;
                        res_reg.accepted    <= acc_reg;
                        res_reg.pixel_value <= pix_reg;
                        state_reg           <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // a pixel read never reports an applied write, and vice versa
    a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.accepted && res_reg.pixel_value))
        else $error("result carries both accepted and pixel_value");

    // a new result only comes out of the hand-off state
    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside hand-off state");

    // a pixel read leaves the store untouched
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY && cmd_reg.op == OP_READ) |-> !mem_we)
        else $error("store written during pixel read");

    // the clearing pass writes zeros and keeps commands out
    a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (mem_we && mem_wdata == 8'h00 && cmd_stall))
        else $error("clearing pass misbehaves");
`endif

endmodule
